### hdl/three_class_priority_record_queue_core_defines.svh
// Assertion macros used by the checker file.
`ifndef THREE_CLASS_PRIORITY_RECORD_QUEUE_CORE_DEFINES_SVH
`define THREE_CLASS_PRIORITY_RECORD_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define TCPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TCPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tcpq_pkg.sv
package tcpq_pkg;

    // default geometry
    localparam int DEF_CRITICAL_DEPTH = 8;
    localparam int DEF_NORMAL_DEPTH   = 16;
    localparam int DEF_DIAG_DEPTH     = 8;
    localparam int DEF_MAX_PAYLOAD    = 256;

    // field widths
    localparam int OP_W        = 2;
    localparam int PRI_W       = 2;
    localparam int TYPE_W      = 8;
    localparam int LEN_W       = 10;
    localparam int FLAGS_W     = 8;
    localparam int HANDLE_W    = 16;
    localparam int SEL_W       = 4;
    localparam int RECS_W      = 6;
    localparam int BYTES_OUT_W = 14;
    localparam int CNT_W       = 32;

    localparam int RECS_MAX  = (2 ** RECS_W) - 1;
    localparam int BYTES_MAX = (2 ** BYTES_OUT_W) - 1;

    // critical pressure level is depth * 3 / 4
    localparam int PRESS_NUM = 3;
    localparam int PRESS_DEN = 4;

    // command queue between front and back
    localparam int CMDQ_DEPTH = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_READ = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef enum logic [PRI_W-1:0] {
        CLS_CRIT = 2'd0,
        CLS_NORM = 2'd1,
        CLS_DIAG = 2'd2
    } t_cls;

    // priority request code that maps onto the normal class
    localparam logic [PRI_W-1:0] PRI_ALIAS_NORM = 2'd3;

    // statistics counter selects
    localparam logic [SEL_W-1:0] CNT_ACCEPT    = 4'd0;
    localparam logic [SEL_W-1:0] CNT_DROP      = 4'd1;
    localparam logic [SEL_W-1:0] CNT_ENCFAIL   = 4'd2;
    localparam logic [SEL_W-1:0] CNT_DROP_CRIT = 4'd3;
    localparam logic [SEL_W-1:0] CNT_DROP_NORM = 4'd4;
    localparam logic [SEL_W-1:0] CNT_DROP_DIAG = 4'd5;
    localparam logic [SEL_W-1:0] CNT_HW_CRIT   = 4'd6;
    localparam logic [SEL_W-1:0] CNT_HW_NORM   = 4'd7;
    localparam logic [SEL_W-1:0] CNT_HW_DIAG   = 4'd8;
    localparam logic [SEL_W-1:0] CNT_HW_BYTES  = 4'd9;

    typedef struct packed {
        logic [TYPE_W-1:0]   rtype;
        logic [LEN_W-1:0]    len;
        logic [FLAGS_W-1:0]  flags;
        logic [HANDLE_W-1:0] handle;
    } t_rec;

    typedef struct packed {
        t_op              op;
        t_cls             cls;
        logic             enc_fail;
        logic [SEL_W-1:0] sel;
        t_rec             rec;
    } t_cmd;

    typedef struct packed {
        logic                   ok;
        logic [PRI_W-1:0]       prio;
        t_rec                   rec;
        logic                   pressure;
        logic [RECS_W-1:0]      records;
        logic [BYTES_OUT_W-1:0] bytes;
        logic [CNT_W-1:0]       value;
    } t_res;

endpackage

### hdl/tcpq_front.sv
module tcpq_front #(
    parameter int MAX_PAYLOAD = tcpq_pkg::DEF_MAX_PAYLOAD
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [tcpq_pkg::OP_W-1:0]     i_op,
    input  logic [tcpq_pkg::PRI_W-1:0]    i_priority_req,
    input  logic [tcpq_pkg::TYPE_W-1:0]   i_rec_type,
    input  logic [tcpq_pkg::LEN_W-1:0]    i_rec_len,
    input  logic [tcpq_pkg::FLAGS_W-1:0]  i_rec_flags,
    input  logic [tcpq_pkg::HANDLE_W-1:0] i_payload_handle,
    input  logic                          i_payload_present,
    input  logic [tcpq_pkg::SEL_W-1:0]    i_counter_select,
    output logic                          o_cmd_valid,
    output tcpq_pkg::t_cmd                o_cmd,
    input  logic                          i_cmd_take
);

    localparam int PW = (tcpq_pkg::CMDQ_DEPTH > 1) ? $clog2(tcpq_pkg::CMDQ_DEPTH) : 1;
    localparam int CW = $clog2(tcpq_pkg::CMDQ_DEPTH + 1);

    tcpq_pkg::t_cmd r_q [tcpq_pkg::CMDQ_DEPTH];
    logic [PW-1:0]  r_wp, n_wp;
    logic [PW-1:0]  r_rp, n_rp;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           push_fire;
    logic           take_fire;
    tcpq_pkg::t_cmd cmd_in;

    // classify the incoming word
    always_comb begin
        cmd_in.op  = tcpq_pkg::t_op'(i_op);
        cmd_in.cls = (i_priority_req == tcpq_pkg::PRI_ALIAS_NORM) ?
                     tcpq_pkg::CLS_NORM : tcpq_pkg::t_cls'(i_priority_req);
        cmd_in.enc_fail = (i_rec_len > tcpq_pkg::LEN_W'(MAX_PAYLOAD)) ||
                          ((i_rec_len != '0) && !i_payload_present);
        cmd_in.sel        = i_counter_select;
        cmd_in.rec.rtype  = i_rec_type;
        cmd_in.rec.len    = i_rec_len;
        cmd_in.rec.flags  = i_rec_flags;
        cmd_in.rec.handle = i_payload_handle;
    end

    assign o_full      = (r_cnt == CW'(tcpq_pkg::CMDQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign push_fire   = i_push && !o_full;
    assign take_fire   = i_cmd_take && o_cmd_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt + CW'(push_fire) - CW'(take_fire);
        if (push_fire) begin
            n_wp = (r_wp == PW'(tcpq_pkg::CMDQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (take_fire) begin
            n_rp = (r_rp == PW'(tcpq_pkg::CMDQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

### hdl/tcpq_back.sv
module tcpq_back #(
    parameter int CRITICAL_DEPTH = tcpq_pkg::DEF_CRITICAL_DEPTH,
    parameter int NORMAL_DEPTH   = tcpq_pkg::DEF_NORMAL_DEPTH,
    parameter int DIAG_DEPTH     = tcpq_pkg::DEF_DIAG_DEPTH,
    parameter int MAX_PAYLOAD    = tcpq_pkg::DEF_MAX_PAYLOAD
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  tcpq_pkg::t_cmd i_cmd,
    output logic           o_cmd_take,
    output logic           o_res_valid,
    output tcpq_pkg::t_res o_res,
    input  logic           i_pop
);

    localparam int CP_W = (CRITICAL_DEPTH > 1) ? $clog2(CRITICAL_DEPTH) : 1;
    localparam int NP_W = (NORMAL_DEPTH > 1) ? $clog2(NORMAL_DEPTH) : 1;
    localparam int DP_W = (DIAG_DEPTH > 1) ? $clog2(DIAG_DEPTH) : 1;
    localparam int CC_W = $clog2(CRITICAL_DEPTH + 1);
    localparam int NC_W = $clog2(NORMAL_DEPTH + 1);
    localparam int DC_W = $clog2(DIAG_DEPTH + 1);
    localparam int TOTAL_DEPTH = CRITICAL_DEPTH + NORMAL_DEPTH + DIAG_DEPTH;
    localparam int REC_W   = $clog2(TOTAL_DEPTH + 1);
    localparam int BYTES_W = $clog2(TOTAL_DEPTH * MAX_PAYLOAD + 1);
    localparam int REC_EXT_W   = REC_W + tcpq_pkg::RECS_W;
    localparam int BYTES_EXT_W = BYTES_W + tcpq_pkg::BYTES_OUT_W;
    localparam int PRESS_LVL = (CRITICAL_DEPTH * tcpq_pkg::PRESS_NUM) / tcpq_pkg::PRESS_DEN;
    localparam int CNT_W = tcpq_pkg::CNT_W;

    typedef enum logic {
        ST_EXEC,
        ST_DEQ_WAIT
    } t_state;

    // record stores
    tcpq_pkg::t_rec crit_mem [CRITICAL_DEPTH];
    tcpq_pkg::t_rec norm_mem [NORMAL_DEPTH];
    tcpq_pkg::t_rec diag_mem [DIAG_DEPTH];
    tcpq_pkg::t_rec r_rd_c, r_rd_n, r_rd_d;

    t_state r_state, n_state;
    logic [CP_W-1:0] r_head_c, n_head_c, r_tail_c, n_tail_c;
    logic [NP_W-1:0] r_head_n, n_head_n, r_tail_n, n_tail_n;
    logic [DP_W-1:0] r_head_d, n_head_d, r_tail_d, n_tail_d;
    logic [CC_W-1:0] r_cnt_c, n_cnt_c, r_hw_c, n_hw_c;
    logic [NC_W-1:0] r_cnt_n, n_cnt_n, r_hw_n, n_hw_n;
    logic [DC_W-1:0] r_cnt_d, n_cnt_d, r_hw_d, n_hw_d;
    logic [BYTES_W-1:0] r_bytes, n_bytes, r_hw_bytes, n_hw_bytes;
    logic [CNT_W-1:0] r_acc, n_acc, r_drop, n_drop, r_enc, n_enc;
    logic [CNT_W-1:0] r_drop_c, n_drop_c, r_drop_n, n_drop_n, r_drop_d, n_drop_d;
    tcpq_pkg::t_cls r_deq_cls, n_deq_cls;
    logic           r_out_valid, n_out_valid;
    tcpq_pkg::t_res r_res, n_res;

    logic wr_c, wr_n, wr_d, rd_c, rd_n, rd_d;
    logic out_free, pop_fire, enq_full;
    logic res_wr, res_ok;
    logic [tcpq_pkg::PRI_W-1:0] res_prio;
    tcpq_pkg::t_rec res_rec, deq_rec;
    logic [CNT_W-1:0] res_value;
    logic [REC_W-1:0] total;
    logic [REC_EXT_W-1:0] rec_ext;
    logic [BYTES_EXT_W-1:0] bytes_ext;

    assign pop_fire    = i_pop && r_out_valid;
    assign out_free    = !r_out_valid || pop_fire;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;

    always_comb begin
        case (i_cmd.cls)
            tcpq_pkg::CLS_CRIT: enq_full = (r_cnt_c == CC_W'(CRITICAL_DEPTH));
            tcpq_pkg::CLS_DIAG: enq_full = (r_cnt_d == DC_W'(DIAG_DEPTH));
            default:            enq_full = (r_cnt_n == NC_W'(NORMAL_DEPTH));
        endcase
        case (r_deq_cls)
            tcpq_pkg::CLS_CRIT: deq_rec = r_rd_c;
            tcpq_pkg::CLS_DIAG: deq_rec = r_rd_d;
            default:            deq_rec = r_rd_n;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_head_c = r_head_c; n_tail_c = r_tail_c; n_cnt_c = r_cnt_c; n_hw_c = r_hw_c;
        n_head_n = r_head_n; n_tail_n = r_tail_n; n_cnt_n = r_cnt_n; n_hw_n = r_hw_n;
        n_head_d = r_head_d; n_tail_d = r_tail_d; n_cnt_d = r_cnt_d; n_hw_d = r_hw_d;
        n_bytes = r_bytes; n_hw_bytes = r_hw_bytes;
        n_acc = r_acc; n_drop = r_drop; n_enc = r_enc;
        n_drop_c = r_drop_c; n_drop_n = r_drop_n; n_drop_d = r_drop_d;
        n_deq_cls = r_deq_cls;
        n_out_valid = r_out_valid && !pop_fire;
        n_res = r_res;
        wr_c = 1'b0; wr_n = 1'b0; wr_d = 1'b0;
        rd_c = 1'b0; rd_n = 1'b0; rd_d = 1'b0;
        o_cmd_take = 1'b0;
        res_wr = 1'b0;
        res_ok = 1'b0;
        res_prio = '0;
        res_rec = '0;
        res_value = '0;
        total = '0;
        rec_ext = '0;
        bytes_ext = '0;

        case (r_state)
            ST_EXEC: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_take = 1'b1;
                    res_wr = 1'b1;
                    case (i_cmd.op)
                        tcpq_pkg::OP_ENQ: begin
                            if (i_cmd.enc_fail || enq_full) begin
                                n_drop = r_drop + 1'b1;
                                if (i_cmd.enc_fail) begin
                                    n_enc = r_enc + 1'b1;
                                end
                                case (i_cmd.cls)
                                    tcpq_pkg::CLS_CRIT: n_drop_c = r_drop_c + 1'b1;
                                    tcpq_pkg::CLS_DIAG: n_drop_d = r_drop_d + 1'b1;
                                    default:            n_drop_n = r_drop_n + 1'b1;
                                endcase
                            end else begin
                                res_ok = 1'b1;
                                n_acc = r_acc + 1'b1;
                                n_bytes = r_bytes + BYTES_W'(i_cmd.rec.len);
                                if (n_bytes > r_hw_bytes) begin
                                    n_hw_bytes = n_bytes;
                                end
                                case (i_cmd.cls)
                                    tcpq_pkg::CLS_CRIT: begin
                                        wr_c = 1'b1;
                                        n_tail_c = (r_tail_c == CP_W'(CRITICAL_DEPTH - 1)) ?
                                                   '0 : r_tail_c + 1'b1;
                                        n_cnt_c = r_cnt_c + 1'b1;
                                        if (n_cnt_c > r_hw_c) begin
                                            n_hw_c = n_cnt_c;
                                        end
                                    end
                                    tcpq_pkg::CLS_DIAG: begin
                                        wr_d = 1'b1;
                                        n_tail_d = (r_tail_d == DP_W'(DIAG_DEPTH - 1)) ?
                                                   '0 : r_tail_d + 1'b1;
                                        n_cnt_d = r_cnt_d + 1'b1;
                                        if (n_cnt_d > r_hw_d) begin
                                            n_hw_d = n_cnt_d;
                                        end
                                    end
                                    default: begin
                                        wr_n = 1'b1;
                                        n_tail_n = (r_tail_n == NP_W'(NORMAL_DEPTH - 1)) ?
                                                   '0 : r_tail_n + 1'b1;
                                        n_cnt_n = r_cnt_n + 1'b1;
                                        if (n_cnt_n > r_hw_n) begin
                                            n_hw_n = n_cnt_n;
                                        end
                                    end
                                endcase
                            end
                        end
                        tcpq_pkg::OP_DEQ: begin
                            // issue the store read; the word is built next cycle
                            if (r_cnt_c != '0) begin
                                rd_c = 1'b1;
                                n_head_c = (r_head_c == CP_W'(CRITICAL_DEPTH - 1)) ?
                                           '0 : r_head_c + 1'b1;
                                n_cnt_c = r_cnt_c - 1'b1;
                                n_deq_cls = tcpq_pkg::CLS_CRIT;
                                n_state = ST_DEQ_WAIT;
                                res_wr = 1'b0;
                            end else if (r_cnt_n != '0) begin
                                rd_n = 1'b1;
                                n_head_n = (r_head_n == NP_W'(NORMAL_DEPTH - 1)) ?
                                           '0 : r_head_n + 1'b1;
                                n_cnt_n = r_cnt_n - 1'b1;
                                n_deq_cls = tcpq_pkg::CLS_NORM;
                                n_state = ST_DEQ_WAIT;
                                res_wr = 1'b0;
                            end else if (r_cnt_d != '0) begin
                                rd_d = 1'b1;
                                n_head_d = (r_head_d == DP_W'(DIAG_DEPTH - 1)) ?
                                           '0 : r_head_d + 1'b1;
                                n_cnt_d = r_cnt_d - 1'b1;
                                n_deq_cls = tcpq_pkg::CLS_DIAG;
                                n_state = ST_DEQ_WAIT;
                                res_wr = 1'b0;
                            end
                        end
                        tcpq_pkg::OP_READ: begin
                            res_ok = 1'b1;
                            case (i_cmd.sel)
                                tcpq_pkg::CNT_ACCEPT:    res_value = r_acc;
                                tcpq_pkg::CNT_DROP:      res_value = r_drop;
                                tcpq_pkg::CNT_ENCFAIL:   res_value = r_enc;
                                tcpq_pkg::CNT_DROP_CRIT: res_value = r_drop_c;
                                tcpq_pkg::CNT_DROP_NORM: res_value = r_drop_n;
                                tcpq_pkg::CNT_DROP_DIAG: res_value = r_drop_d;
                                tcpq_pkg::CNT_HW_CRIT:   res_value = CNT_W'(r_hw_c);
                                tcpq_pkg::CNT_HW_NORM:   res_value = CNT_W'(r_hw_n);
                                tcpq_pkg::CNT_HW_DIAG:   res_value = CNT_W'(r_hw_d);
                                tcpq_pkg::CNT_HW_BYTES:  res_value = CNT_W'(r_hw_bytes);
                                default: begin
                                    res_ok = 1'b0;
                                    res_value = '0;
                                end
                            endcase
                        end
                        default: begin
                            res_ok = 1'b0;
                        end
                    endcase
                end
            end
            ST_DEQ_WAIT: begin
                // store data has landed: release its bytes and show the record
                if (r_bytes >= BYTES_W'(deq_rec.len)) begin
                    n_bytes = r_bytes - BYTES_W'(deq_rec.len);
                end else begin
                    n_bytes = '0;
                end
                res_wr = 1'b1;
                res_ok = 1'b1;
                res_prio = r_deq_cls;
                res_rec = deq_rec;
                n_state = ST_EXEC;
            end
            default: begin
                n_state = ST_EXEC;
            end
        endcase

        if (res_wr) begin
            total = REC_W'(n_cnt_c) + REC_W'(n_cnt_n) + REC_W'(n_cnt_d);
            rec_ext = REC_EXT_W'(total);
            bytes_ext = BYTES_EXT_W'(n_bytes);
            n_out_valid = 1'b1;
            n_res.ok = res_ok;
            n_res.prio = res_prio;
            n_res.rec = res_rec;
            n_res.value = res_value;
            n_res.pressure = (int'(n_cnt_n) >= NORMAL_DEPTH) ||
                             (int'(n_cnt_d) >= DIAG_DEPTH) ||
                             (int'(n_cnt_c) >= PRESS_LVL);
            n_res.records = (rec_ext > REC_EXT_W'(tcpq_pkg::RECS_MAX)) ?
                            tcpq_pkg::RECS_W'(tcpq_pkg::RECS_MAX) :
                            rec_ext[tcpq_pkg::RECS_W-1:0];
            n_res.bytes = (bytes_ext > BYTES_EXT_W'(tcpq_pkg::BYTES_MAX)) ?
                          tcpq_pkg::BYTES_OUT_W'(tcpq_pkg::BYTES_MAX) :
                          bytes_ext[tcpq_pkg::BYTES_OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_EXEC;
            r_head_c <= '0; r_tail_c <= '0; r_cnt_c <= '0; r_hw_c <= '0;
            r_head_n <= '0; r_tail_n <= '0; r_cnt_n <= '0; r_hw_n <= '0;
            r_head_d <= '0; r_tail_d <= '0; r_cnt_d <= '0; r_hw_d <= '0;
            r_bytes <= '0; r_hw_bytes <= '0;
            r_acc <= '0; r_drop <= '0; r_enc <= '0;
            r_drop_c <= '0; r_drop_n <= '0; r_drop_d <= '0;
            r_deq_cls <= tcpq_pkg::CLS_CRIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head_c <= n_head_c; r_tail_c <= n_tail_c; r_cnt_c <= n_cnt_c; r_hw_c <= n_hw_c;
            r_head_n <= n_head_n; r_tail_n <= n_tail_n; r_cnt_n <= n_cnt_n; r_hw_n <= n_hw_n;
            r_head_d <= n_head_d; r_tail_d <= n_tail_d; r_cnt_d <= n_cnt_d; r_hw_d <= n_hw_d;
            r_bytes <= n_bytes; r_hw_bytes <= n_hw_bytes;
            r_acc <= n_acc; r_drop <= n_drop; r_enc <= n_enc;
            r_drop_c <= n_drop_c; r_drop_n <= n_drop_n; r_drop_d <= n_drop_d;
            r_deq_cls <= n_deq_cls;
            r_out_valid <= n_out_valid;
        end
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (wr_c) begin
            crit_mem[r_tail_c] <= i_cmd.rec;
        end
        if (wr_n) begin
            norm_mem[r_tail_n] <= i_cmd.rec;
        end
        if (wr_d) begin
            diag_mem[r_tail_d] <= i_cmd.rec;
        end
        if (rd_c) begin
            r_rd_c <= crit_mem[r_head_c];
        end
        if (rd_n) begin
            r_rd_n <= norm_mem[r_head_n];
        end
        if (rd_d) begin
            r_rd_d <= diag_mem[r_head_d];
        end
    end

endmodule

### hdl/three_class_priority_record_queue_core.sv
// A pushed word passes the front queue and then the result register before it shows on the
// result side; a dequeue that finds a record also waits on the registered record store read.
// Throughput: one word per cycle while the result register is free or popped; a dequeue
// that finds a record holds the execute stage (store read, then result from the read data).
// Reset (i_rst_n low at a clock edge) clears pointers, counts, byte total, statistics and
// both queues; the record stores keep their contents and need no clearing pass.
module three_class_priority_record_queue_core #(
    parameter int CRITICAL_DEPTH = tcpq_pkg::DEF_CRITICAL_DEPTH,
    parameter int NORMAL_DEPTH   = tcpq_pkg::DEF_NORMAL_DEPTH,
    parameter int DIAG_DEPTH     = tcpq_pkg::DEF_DIAG_DEPTH,
    parameter int MAX_PAYLOAD    = tcpq_pkg::DEF_MAX_PAYLOAD
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command side
    input  logic                             push,
    output logic                             full,
    input  logic [tcpq_pkg::OP_W-1:0]        i_op,
    input  logic [tcpq_pkg::PRI_W-1:0]       i_priority_req,
    input  logic [tcpq_pkg::TYPE_W-1:0]      i_rec_type,
    input  logic [tcpq_pkg::LEN_W-1:0]       i_rec_len,
    input  logic [tcpq_pkg::FLAGS_W-1:0]     i_rec_flags,
    input  logic [tcpq_pkg::HANDLE_W-1:0]    i_payload_handle,
    input  logic                             i_payload_present,
    input  logic [tcpq_pkg::SEL_W-1:0]       i_counter_select,
    // result side
    output logic                             empty,
    input  logic                             pop,
    output logic                             o_ok,
    output logic [tcpq_pkg::PRI_W-1:0]       o_out_priority,
    output logic [tcpq_pkg::TYPE_W-1:0]      o_out_type,
    output logic [tcpq_pkg::LEN_W-1:0]       o_out_len,
    output logic [tcpq_pkg::FLAGS_W-1:0]     o_out_flags,
    output logic [tcpq_pkg::HANDLE_W-1:0]    o_out_handle,
    output logic                             o_pressure,
    output logic [tcpq_pkg::RECS_W-1:0]      o_queued_records,
    output logic [tcpq_pkg::BYTES_OUT_W-1:0] o_queued_bytes,
    output logic [tcpq_pkg::CNT_W-1:0]       o_counter_value
);

    logic           cmd_valid;
    logic           cmd_take;
    tcpq_pkg::t_cmd cmd;
    logic           res_valid;
    tcpq_pkg::t_res res;

    // Front: decode the op, fold priority code 3 onto the normal class, flag
    // over-long or payload-less records as encode failures, and hold the decoded
    // word in a two-entry queue so the push side keeps moving while the back stalls.
    tcpq_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .o_full            (full),
        .i_op              (i_op),
        .i_priority_req    (i_priority_req),
        .i_rec_type        (i_rec_type),
        .i_rec_len         (i_rec_len),
        .i_rec_flags       (i_rec_flags),
        .i_payload_handle  (i_payload_handle),
        .i_payload_present (i_payload_present),
        .i_counter_select  (i_counter_select),
        .o_cmd_valid       (cmd_valid),
        .o_cmd             (cmd),
        .i_cmd_take        (cmd_take)
    );

    // Back: own the three ring stores, pointers, byte total and statistics. Execute one
    // decoded word whenever no dequeue is being finished and the result register is free
    // or is drained this cycle; serve dequeues in strict critical/normal/diagnostic order.
    tcpq_back #(
        .CRITICAL_DEPTH (CRITICAL_DEPTH),
        .NORMAL_DEPTH   (NORMAL_DEPTH),
        .DIAG_DEPTH     (DIAG_DEPTH),
        .MAX_PAYLOAD    (MAX_PAYLOAD)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_pop       (pop)
    );

    // Drive the result ports straight from the back's result register.
    assign empty            = !res_valid;
    assign o_ok             = res.ok;
    assign o_out_priority   = res.prio;
    assign o_out_type       = res.rec.rtype;
    assign o_out_len        = res.rec.len;
    assign o_out_flags      = res.rec.flags;
    assign o_out_handle     = res.rec.handle;
    assign o_pressure       = res.pressure;
    assign o_queued_records = res.records;
    assign o_queued_bytes   = res.bytes;
    assign o_counter_value  = res.value;

endmodule

### hdl/tcpq_checker.sv
`include "three_class_priority_record_queue_core_defines.svh"

module tcpq_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             empty,
    input logic                             pop,
    input logic                             o_ok,
    input logic [tcpq_pkg::PRI_W-1:0]       o_out_priority,
    input logic [tcpq_pkg::TYPE_W-1:0]      o_out_type,
    input logic [tcpq_pkg::LEN_W-1:0]       o_out_len,
    input logic [tcpq_pkg::FLAGS_W-1:0]     o_out_flags,
    input logic [tcpq_pkg::HANDLE_W-1:0]    o_out_handle,
    input logic [tcpq_pkg::RECS_W-1:0]      o_queued_records,
    input logic [tcpq_pkg::BYTES_OUT_W-1:0] o_queued_bytes,
    input logic [tcpq_pkg::CNT_W-1:0]       o_counter_value
);

    // a waiting result holds until it is popped
    `TCPQ_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(o_ok) && $stable(o_out_handle) && $stable(o_counter_value), "result changed while stalled")

    // a failed step carries no record
    `TCPQ_ASSERT_NOW(a_fail_no_rec, !empty && !o_ok, o_out_priority == '0 && o_out_type == '0 && o_out_len == '0 && o_out_flags == '0 && o_out_handle == '0, "record fields set on a failed step")

    // no queued bytes without queued records
    `TCPQ_ASSERT_NOW(a_bytes_need_recs, !empty && o_queued_records == '0, o_queued_bytes == '0, "bytes queued with no records")

    // a counter value only comes with a good read
    `TCPQ_ASSERT_NOW(a_value_needs_ok, !empty && o_counter_value != '0, o_ok && o_out_len == '0, "counter value without a good read")

endmodule

bind three_class_priority_record_queue_core tcpq_checker u_tcpq_checker (.*);
